// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- rtl/rbsa_pkg.sv -----
// Package: types, constants and codes of the reference-counted buffer pool.
`default_nettype none
package rbsa_pkg;
   localparam int NUM_BUFFERS = 16;
   localparam int STACK_DEPTH = 32;
   localparam int BUF_W = $clog2(NUM_BUFFERS);
   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = 7;

   localparam logic [3:0] OP_RESET = 4'd0;
   localparam logic [3:0] OP_PUSH_NEW = 4'd1;
   localparam logic [3:0] OP_PUSH_ID = 4'd2;
   localparam logic [3:0] OP_POP = 4'd3;
   localparam logic [3:0] OP_DUP = 4'd4;
   localparam logic [3:0] OP_DROP = 4'd5;
   localparam logic [3:0] OP_SWAP = 4'd6;
   localparam logic [3:0] OP_HOLD_POP = 4'd7;
   localparam logic [3:0] OP_UHOLD_POP = 4'd8;
   localparam logic [3:0] OP_UHOLD = 4'd9;
   localparam logic [3:0] OP_URELEASE = 4'd10;
   localparam logic [3:0] OP_RELEASE_HOLD = 4'd11;
   localparam logic [3:0] OP_URELEASE_ALL = 4'd12;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_REFUSED = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   localparam logic [CNT_W-1:0] CNT_HELD = 7'h7F;
   localparam logic [CNT_W-1:0] CNT_UHELD = 7'h7E;
   localparam logic [CNT_W-1:0] CNT_MAX = 7'd63;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;
endpackage
`default_nettype wire

// ----- rtl/rbsa_ram.sv -----
// Generic single-write RAM with a registered read port.
`default_nettype none
module rbsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/rbsa_ctrl.sv -----
// Controller: sequences load, execute and result delivery of one command.
`default_nettype none
module rbsa_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input wire logic out_ready,
   output rbsa_pkg::cmd_type cmd
);
   rbsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbsa_pkg::S_IDLE: if (in_valid) state_in = rbsa_pkg::S_EXEC;
         rbsa_pkg::S_EXEC: state_in = rbsa_pkg::S_OUT;
         rbsa_pkg::S_OUT: begin
            if (out_ready) begin
               state_in = in_valid ? rbsa_pkg::S_EXEC : rbsa_pkg::S_IDLE;
            end
         end
         default: state_in = rbsa_pkg::S_IDLE;
      endcase
   end

   // A new beat is taken as the finished result leaves.
   always_comb begin
      in_ready = 1'b0;
      out_valid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         rbsa_pkg::S_IDLE: in_ready = 1'b1;
         rbsa_pkg::S_EXEC: cmd.exec = 1'b1;
         rbsa_pkg::S_OUT: begin
            out_valid = 1'b1;
            in_ready = out_ready;
         end
         default: ;
      endcase
      cmd.load = in_valid & in_ready;
   end
endmodule
`default_nettype wire

// ----- rtl/rbsa_dp.sv -----
// Datapath: counters, totals, hint, stack memory and result register.
`default_nettype none
module rbsa_dp (
   input wire logic clock,
   input wire logic reset,
   input wire rbsa_pkg::cmd_type cmd,
   input wire logic [3:0] opcode,
   input wire logic [3:0] buffer_id,
   input wire logic csr_wr_en,
   input wire logic [0:0] csr_index,
   input wire logic [5:0] csr_wr_data,
   output logic [2:0] status,
   output logic [3:0] result_buffer,
   output logic [5:0] active_count,
   output logic [4:0] user_hold_count,
   output logic [5:0] stack_depth
);
   localparam int NB = rbsa_pkg::NUM_BUFFERS;
   localparam int CW = rbsa_pkg::CNT_W;

   logic [4:0] biu_ff;
   logic [5:0] slim_ff;
   logic [3:0] op_ff;
   logic [3:0] id_ff;
   logic [CW-1:0] cnt_ff [NB];
   logic [CW-1:0] cnt_in [NB];
   logic [5:0] sp_ff, sp_in;
   logic [5:0] act_ff, act_in;
   logic [4:0] usr_ff, usr_in;
   logic hint_v_ff, hint_v_in;
   logic [3:0] hint_ff, hint_in;
   logic [2:0] st_ff, st_in;
   logic [3:0] rb_ff, rb_in;
   logic [3:0] top_ff;
   logic [3:0] nxt_ff;
   logic swp_ff;
   logic [3:0] swp_top_ff, swp_nxt_ff;

   logic [5:0] size, cap;
   logic wr_en, wr2_en;
   logic [4:0] wr_addr, rd_addr, rd2_addr;
   logic [3:0] wr_data;
   logic [3:0] rd_data, rd2_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff <= 5'd16;
         slim_ff <= 6'd32;
      end else if (csr_wr_en) begin
         if (csr_index == 1'b0) biu_ff <= csr_wr_data[4:0];
         else slim_ff <= csr_wr_data;
      end
   end

   assign size = (biu_ff > 5'(NB)) ? 6'(NB) : {1'b0, biu_ff};
   assign cap = (slim_ff > 6'(rbsa_pkg::STACK_DEPTH)) ? 6'(rbsa_pkg::STACK_DEPTH) : slim_ff;

   // Stack memory: two read ports give the top two entries for swap.
   assign rd_addr = (cmd.load ? sp_ff[4:0] : sp_ff[4:0]) - 5'd1;
   assign rd2_addr = sp_ff[4:0] - 5'd2;
   // Swap writes one entry of each copy while executing and the other entry of each
   // copy in the following cycle, so both copies agree before the next read is used.
   rbsa_ram #(.WIDTH(4), .DEPTH(rbsa_pkg::STACK_DEPTH)) u_ram_a (
      .clock, .wr_en(wr_en | swp_ff), .wr_addr(swp_ff ? rd2_addr : wr_addr),
      .wr_data(swp_ff ? swp_top_ff : wr_data), .rd_addr, .rd_data);
   rbsa_ram #(.WIDTH(4), .DEPTH(rbsa_pkg::STACK_DEPTH)) u_ram_b (
      .clock, .wr_en(wr_en | swp_ff),
      .wr_addr(wr2_en ? rd2_addr : (swp_ff ? rd_addr : wr_addr)),
      .wr_data(wr2_en ? top_ff : (swp_ff ? swp_nxt_ff : wr_data)),
      .rd_addr(rd2_addr), .rd_data(rd2_data));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode;
         id_ff <= buffer_id;
      end
   end
   assign top_ff = rd_data;
   assign nxt_ff = rd2_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         swp_ff <= 1'b0;
      end else begin
         swp_ff <= wr2_en;
      end
      if (wr2_en) begin
         swp_top_ff <= top_ff;
         swp_nxt_ff <= nxt_ff;
      end
   end

   logic [3:0] found_b;
   logic found;
   always_comb begin
      found = 1'b0;
      found_b = '0;
      for (int i = NB - 1; i >= 0; i--) begin
         if (6'(i) < size && cnt_ff[i] == '0) begin
            found = 1'b1;
            found_b = 4'(i);
         end
      end
   end

   logic [CW-1:0] c;
   logic [3:0] b;
   logic named;
   always_comb begin
      for (int i = 0; i < NB; i++) cnt_in[i] = cnt_ff[i];
      sp_in = sp_ff;
      act_in = act_ff;
      usr_in = usr_ff;
      hint_v_in = hint_v_ff;
      hint_in = hint_ff;
      st_in = rbsa_pkg::ST_OK;
      rb_in = '0;
      wr_en = 1'b0;
      wr2_en = 1'b0;
      wr_addr = sp_ff[4:0];
      wr_data = '0;
      b = '0;
      c = cnt_ff[id_ff];
      named = op_ff == rbsa_pkg::OP_PUSH_ID || op_ff == rbsa_pkg::OP_UHOLD
         || op_ff == rbsa_pkg::OP_URELEASE || op_ff == rbsa_pkg::OP_RELEASE_HOLD;
      if (named && {2'b0, id_ff} >= size) begin
         st_in = rbsa_pkg::ST_INVALID;
      end else begin
         unique case (op_ff)
            rbsa_pkg::OP_RESET: begin
               sp_in = '0;
               hint_v_in = 1'b0;
               act_in = '0;
               for (int i = 0; i < NB; i++) begin
                  if (6'(i) < size) begin
                     if (!cnt_ff[i][CW-1]) cnt_in[i] = '0;
                     else act_in = act_in + 6'd1;
                  end
               end
            end
            rbsa_pkg::OP_PUSH_NEW: begin
               if (sp_ff >= cap) st_in = rbsa_pkg::ST_OVERFLOW;
               else if (act_ff >= size) st_in = rbsa_pkg::ST_FULL;
               else if (!(hint_v_ff && {2'b0, hint_ff} < size) && !found)
                  st_in = rbsa_pkg::ST_FULL;
               else begin
                  b = (hint_v_ff && {2'b0, hint_ff} < size) ? hint_ff : found_b;
                  hint_v_in = 1'b0;
                  if (act_ff < 6'd63) act_in = act_ff + 6'd1;
                  if (!cnt_ff[b][CW-1] && cnt_ff[b] < rbsa_pkg::CNT_MAX)
                     cnt_in[b] = cnt_ff[b] + 7'd1;
                  wr_en = 1'b1;
                  wr_data = b;
                  sp_in = sp_ff + 6'd1;
                  rb_in = b;
               end
            end
            rbsa_pkg::OP_PUSH_ID: begin
               if (sp_ff >= cap) st_in = rbsa_pkg::ST_OVERFLOW;
               else begin
                  wr_en = 1'b1;
                  wr_data = id_ff;
                  sp_in = sp_ff + 6'd1;
                  rb_in = id_ff;
               end
            end
            rbsa_pkg::OP_POP, rbsa_pkg::OP_UHOLD_POP: begin
               if (sp_ff == '0) st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  b = top_ff;
                  sp_in = sp_ff - 6'd1;
                  rb_in = b;
                  if (!cnt_ff[b][CW-1] && cnt_ff[b] != '0) begin
                     cnt_in[b] = cnt_ff[b] - 7'd1;
                     if (cnt_ff[b] == 7'd1) begin
                        hint_v_in = 1'b1;
                        hint_in = b;
                        if (act_ff != '0) act_in = act_ff - 6'd1;
                     end
                  end
                  if (op_ff == rbsa_pkg::OP_UHOLD_POP) begin
                     hint_v_in = 1'b0;
                     if (!cnt_in[b][CW-1]) begin
                        cnt_in[b] = rbsa_pkg::CNT_UHELD;
                        if (usr_ff < 5'd31) usr_in = usr_ff + 5'd1;
                        if (act_in < 6'd63) act_in = act_in + 6'd1;
                     end
                  end
               end
            end
            rbsa_pkg::OP_DUP: begin
               if (sp_ff == '0 || {1'b0, sp_ff} + 7'd1 >= {1'b0, cap})
                  st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  b = top_ff;
                  rb_in = b;
                  wr_en = 1'b1;
                  wr_data = b;
                  if (!cnt_ff[b][CW-1] && cnt_ff[b] < rbsa_pkg::CNT_MAX)
                     cnt_in[b] = cnt_ff[b] + 7'd1;
                  sp_in = sp_ff + 6'd1;
               end
            end
            rbsa_pkg::OP_DROP: begin
               if (sp_ff == '0) st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  sp_in = sp_ff - 6'd1;
                  rb_in = top_ff;
               end
            end
            rbsa_pkg::OP_SWAP: begin
               if (sp_ff < 6'd2) st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  // The entry below goes on top; the top goes below through port b.
                  wr_en = 1'b1;
                  wr_addr = rd_addr;
                  wr_data = nxt_ff;
               end
            end
            rbsa_pkg::OP_HOLD_POP: begin
               if (sp_ff == '0) st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  sp_in = sp_ff - 6'd1;
                  rb_in = top_ff;
                  cnt_in[top_ff] = rbsa_pkg::CNT_HELD;
               end
            end
            rbsa_pkg::OP_UHOLD: begin
               rb_in = id_ff;
               hint_v_in = 1'b0;
               if (!c[CW-1]) begin
                  cnt_in[id_ff] = rbsa_pkg::CNT_UHELD;
                  if (usr_ff < 5'd31) usr_in = usr_ff + 5'd1;
                  if (act_ff < 6'd63) act_in = act_ff + 6'd1;
               end else st_in = rbsa_pkg::ST_INVALID;
            end
            rbsa_pkg::OP_URELEASE: begin
               rb_in = id_ff;
               if (c != rbsa_pkg::CNT_UHELD) st_in = rbsa_pkg::ST_INVALID;
               else begin
                  cnt_in[id_ff] = '0;
                  if (act_ff != '0) act_in = act_ff - 6'd1;
                  if (usr_ff != '0) usr_in = usr_ff - 5'd1;
               end
            end
            rbsa_pkg::OP_RELEASE_HOLD: begin
               rb_in = id_ff;
               if (c[CW-1]) begin
                  cnt_in[id_ff] = '0;
                  if (act_ff != '0) act_in = act_ff - 6'd1;
               end else st_in = rbsa_pkg::ST_REFUSED;
            end
            rbsa_pkg::OP_URELEASE_ALL: begin
               if (usr_ff == '0) st_in = rbsa_pkg::ST_REFUSED;
               else begin
                  for (int i = 0; i < NB; i++) begin
                     if (6'(i) < size && cnt_ff[i] == rbsa_pkg::CNT_UHELD) begin
                        cnt_in[i] = '0;
                        if (act_in != '0) act_in = act_in - 6'd1;
                        if (usr_in != '0) usr_in = usr_in - 5'd1;
                     end
                  end
               end
            end
            default: st_in = rbsa_pkg::ST_REFUSED;
         endcase
      end
      if (st_in != rbsa_pkg::ST_OK && st_in != rbsa_pkg::ST_INVALID) rb_in = '0;
      if (st_in == rbsa_pkg::ST_INVALID && {2'b0, id_ff} >= size) rb_in = '0;
      if (!cmd.exec) begin
         wr_en = 1'b0;
      end
      if (cmd.exec && op_ff == rbsa_pkg::OP_SWAP && st_in == rbsa_pkg::ST_OK)
         wr2_en = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) cnt_ff[i] <= '0;
         sp_ff <= '0;
         act_ff <= '0;
         usr_ff <= '0;
         hint_v_ff <= 1'b0;
         hint_ff <= '0;
      end else if (cmd.exec) begin
         for (int i = 0; i < NB; i++) cnt_ff[i] <= cnt_in[i];
         sp_ff <= sp_in;
         act_ff <= act_in;
         usr_ff <= usr_in;
         hint_v_ff <= hint_v_in;
         hint_ff <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         st_ff <= st_in;
         rb_ff <= rb_in;
      end
   end

   assign status = st_ff;
   assign result_buffer = rb_ff;
   assign active_count = act_ff;
   assign user_hold_count = usr_ff;
   assign stack_depth = sp_ff;
endmodule
`default_nettype wire

// ----- rtl/refcounted_buffer_stack_allocator.sv -----
// Top level of the reference-counted buffer pool with its buffer id stack.
`default_nettype none
// Each command beat is stored, executed in the following cycle and shown as a result
// beat in the cycle after that; a new beat is taken while the result leaves, and not
// before, so commands do not overlap.
module refcounted_buffer_stack_allocator (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [7:0] req_tdata, // opcode[3:0], buffer_id[7:4]
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [23:0] rsp_tdata, // status, result_buffer, active_count,
                                  // user_hold_count, stack_depth
   input wire logic csr_wr_en,
   input wire logic [0:0] csr_index,
   input wire logic [5:0] csr_wr_data
);
   rbsa_pkg::cmd_type cmd;
   logic [2:0] status;
   logic [3:0] result_buffer;
   logic [5:0] active_count;
   logic [4:0] user_hold_count;
   logic [5:0] stack_depth;

   rbsa_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd);

   rbsa_dp u_dp (
      .clock, .reset, .cmd, .opcode(req_tdata[3:0]), .buffer_id(req_tdata[7:4]),
      .csr_wr_en, .csr_index, .csr_wr_data, .status, .result_buffer,
      .active_count, .user_hold_count, .stack_depth);

   assign rsp_tdata = {stack_depth, user_hold_count, active_count, result_buffer, status};
endmodule
`default_nettype wire

// ----- rtl/rbsa_checker.sv -----
// Port checker for the buffer pool top level, bound to it.
`default_nettype none
`include "assert_macros.svh"
module rbsa_port_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   `ASSERT_IMPLIES(a_status_range, clock, reset, rsp_tvalid, rsp_tdata[2:0] <= 3'd4)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_one_result, clock, reset, req_tvalid && req_tready, !rsp_tvalid)
   `ASSERT_IMPLIES(a_depth, clock, reset, rsp_tvalid, rsp_tdata[23:18] <= 6'd32)
endmodule

bind refcounted_buffer_stack_allocator rbsa_port_checker u_rbsa_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata);
`default_nettype wire

// ----- tb/rbsa_checker.sv -----
// Checker for the buffer pool: watches the channels, predicts each result beat and compares.
module rbsa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [7:0] req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [23:0] rsp_data,
   input wire logic csr_wr_en,
   input wire logic [0:0] csr_index,
   input wire logic [5:0] csr_wr_data,
   output int fail_count
);
   // Fields from the highest bit down, so that status lands in the lowest bits.
   typedef struct packed {
      logic [5:0] depth;
      logic [4:0] uheld;
      logic [5:0] active;
      logic [3:0] buf_id;
      logic [2:0] status;
   } pool_result_type;

   logic [4:0] pool_cfg;
   logic [5:0] cap_cfg;
   int refs [rbsa_pkg::NUM_BUFFERS];
   logic [3:0] id_stack [rbsa_pkg::STACK_DEPTH];
   int sp;
   int active_tot;
   int uheld_tot;
   logic hint_ok;
   int hint_id;
   int fails = 0;
   pool_result_type expected_q[$];

   assign fail_count = fails;

   task automatic clear_pool();
      pool_cfg = 5'd16;
      cap_cfg = 6'd32;
      foreach (refs[i]) refs[i] = 0;
      sp = 0;
      active_tot = 0;
      uheld_tot = 0;
      hint_ok = 1'b0;
      hint_id = 0;
      expected_q.delete();
   endtask

   function automatic void bump_active(int d);
      if (d > 0 && active_tot < 63) active_tot++;
      if (d < 0 && active_tot > 0) active_tot--;
   endfunction

   function automatic void bump_uheld(int d);
      if (d > 0 && uheld_tot < 31) uheld_tot++;
      if (d < 0 && uheld_tot > 0) uheld_tot--;
   endfunction

   // Take the top entry off, drop one reader and free the buffer when no reader is left.
   function automatic int pop_reader();
      int b;
      sp--;
      b = id_stack[sp];
      if (refs[b] > 0) begin
         refs[b]--;
         if (refs[b] == 0) begin
            hint_ok = 1'b1;
            hint_id = b;
            bump_active(-1);
         end
      end
      return b;
   endfunction

   function automatic pool_result_type run_command(logic [3:0] op, logic [3:0] id);
      pool_result_type r;
      int size;
      int cap;
      int b;
      int t;
      logic [2:0] st;
      logic found;
      logic named;
      size = (pool_cfg < rbsa_pkg::NUM_BUFFERS) ? pool_cfg : rbsa_pkg::NUM_BUFFERS;
      cap = (cap_cfg < rbsa_pkg::STACK_DEPTH) ? cap_cfg : rbsa_pkg::STACK_DEPTH;
      st = rbsa_pkg::ST_OK;
      b = 0;
      named = (op == rbsa_pkg::OP_PUSH_ID || op == rbsa_pkg::OP_UHOLD ||
               op == rbsa_pkg::OP_URELEASE || op == rbsa_pkg::OP_RELEASE_HOLD);
      if (named && id >= size) begin
         st = rbsa_pkg::ST_INVALID;
      end else begin
         case (op)
            rbsa_pkg::OP_RESET: begin
               sp = 0;
               hint_ok = 1'b0;
               active_tot = 0;
               for (int i = 0; i < size; i++)
                  if (refs[i] >= 0) refs[i] = 0;
                  else bump_active(1);
            end
            rbsa_pkg::OP_PUSH_NEW: begin
               found = 1'b0;
               if (sp >= cap) st = rbsa_pkg::ST_OVERFLOW;
               else if (active_tot >= size) st = rbsa_pkg::ST_FULL;
               else begin
                  if (hint_ok && hint_id < size) begin
                     b = hint_id;
                     found = 1'b1;
                  end else begin
                     for (int i = 0; i < size && !found; i++)
                        if (refs[i] == 0) begin
                           b = i;
                           found = 1'b1;
                        end
                  end
                  if (!found) st = rbsa_pkg::ST_FULL;
                  else begin
                     hint_ok = 1'b0;
                     bump_active(1);
                     if (refs[b] >= 0 && refs[b] < 63) refs[b]++;
                     id_stack[sp] = b;
                     sp++;
                  end
               end
            end
            rbsa_pkg::OP_PUSH_ID: begin
               if (sp >= cap) st = rbsa_pkg::ST_OVERFLOW;
               else begin
                  id_stack[sp] = id;
                  sp++;
                  b = id;
               end
            end
            rbsa_pkg::OP_POP: begin
               if (sp == 0) st = rbsa_pkg::ST_REFUSED;
               else b = pop_reader();
            end
            rbsa_pkg::OP_DUP: begin
               if (sp == 0 || sp >= cap - 1) st = rbsa_pkg::ST_REFUSED;
               else begin
                  b = id_stack[sp-1];
                  id_stack[sp] = b;
                  if (refs[b] >= 0 && refs[b] < 63) refs[b]++;
                  sp++;
               end
            end
            rbsa_pkg::OP_DROP: begin
               if (sp == 0) st = rbsa_pkg::ST_REFUSED;
               else begin
                  sp--;
                  b = id_stack[sp];
               end
            end
            rbsa_pkg::OP_SWAP: begin
               if (sp < 2) st = rbsa_pkg::ST_REFUSED;
               else begin
                  t = id_stack[sp-1];
                  id_stack[sp-1] = id_stack[sp-2];
                  id_stack[sp-2] = t;
               end
            end
            rbsa_pkg::OP_HOLD_POP: begin
               if (sp == 0) st = rbsa_pkg::ST_REFUSED;
               else begin
                  sp--;
                  b = id_stack[sp];
                  refs[b] = -1;
               end
            end
            rbsa_pkg::OP_UHOLD_POP: begin
               if (sp == 0) st = rbsa_pkg::ST_REFUSED;
               else begin
                  b = pop_reader();
                  hint_ok = 1'b0;
                  if (refs[b] >= 0) begin
                     refs[b] = -2;
                     bump_uheld(1);
                     bump_active(1);
                  end
               end
            end
            rbsa_pkg::OP_UHOLD: begin
               b = id;
               if (refs[id] >= 0) begin
                  refs[id] = -2;
                  bump_uheld(1);
                  bump_active(1);
               end else st = rbsa_pkg::ST_INVALID;
               hint_ok = 1'b0;
            end
            rbsa_pkg::OP_URELEASE: begin
               b = id;
               if (refs[id] != -2) st = rbsa_pkg::ST_INVALID;
               else begin
                  refs[id] = 0;
                  bump_active(-1);
                  bump_uheld(-1);
               end
            end
            rbsa_pkg::OP_RELEASE_HOLD: begin
               b = id;
               if (refs[id] < 0) begin
                  refs[id] = 0;
                  bump_active(-1);
               end else st = rbsa_pkg::ST_REFUSED;
            end
            rbsa_pkg::OP_URELEASE_ALL: begin
               if (uheld_tot == 0) st = rbsa_pkg::ST_REFUSED;
               else
                  for (int i = 0; i < size; i++)
                     if (refs[i] == -2) begin
                        refs[i] = 0;
                        bump_active(-1);
                        bump_uheld(-1);
                     end
            end
            default: st = rbsa_pkg::ST_REFUSED;
         endcase
      end
      if (st != rbsa_pkg::ST_OK && st != rbsa_pkg::ST_INVALID) b = 0;
      if (st == rbsa_pkg::ST_INVALID && id >= size) b = 0;
      r.status = st;
      r.buf_id = b[3:0];
      r.active = active_tot[5:0];
      r.uheld = uheld_tot[4:0];
      r.depth = sp[5:0];
      return r;
   endfunction

   initial begin
      clear_pool();
   end

   always @(posedge clock) begin
      pool_result_type got;
      pool_result_type want;
      if (reset) begin
         clear_pool();
      end else begin
         // Results are taken before commands: no result can leave in the cycle its command enters.
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_data);
               fails++;
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.buf_id !== want.buf_id ||
                   got.active !== want.active || got.uheld !== want.uheld ||
                   got.depth !== want.depth) begin
                  $display("%0t: mismatch expected st=%0d buf=%0d act=%0d uh=%0d dep=%0d",
                           $time, want.status, want.buf_id, want.active, want.uheld,
                           want.depth);
                  $display("%0t:          actual   st=%0d buf=%0d act=%0d uh=%0d dep=%0d",
                           $time, got.status, got.buf_id, got.active, got.uheld, got.depth);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(run_command(req_data[3:0], req_data[7:4]));
         if (csr_wr_en) begin
            if (csr_index == 1'b0) pool_cfg = csr_wr_data[4:0];
            else cap_cfg = csr_wr_data;
         end
      end
   end

   // Left-over expectations are reported by the top through this count.
   function automatic int outstanding();
      return expected_q.size();
   endfunction
endmodule

// ----- tb/refcounted_buffer_stack_allocator_tb.sv -----
// Testbench top for the buffer pool: clock, reset, stimulus, stalls and the verdict.
module refcounted_buffer_stack_allocator_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data = 8'd0; // opcode[3:0], buffer_id[7:4]
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_data; // status, result_buffer, active_count, user_hold_count, stack_depth
   logic csr_wr_en = 1'b0;
   logic [0:0] csr_index = 1'b0;
   logic [5:0] csr_wr_data = 6'd0;
   int fail_count;
   int sent_beats = 0;
   int got_beats = 0;
   logic no_idle = 1'b0;
   logic stall_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   refcounted_buffer_stack_allocator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_valid),
      .req_tready(req_ready),
      .req_tdata(req_data),
      .rsp_tvalid(rsp_valid),
      .rsp_tready(rsp_ready),
      .rsp_tdata(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   rbsa_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count)
   );

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sent_beats <= sent_beats + 1;
      if (!reset && rsp_valid && rsp_ready) got_beats <= got_beats + 1;
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request && hold_left == 0) begin
            hold_left = 250;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 18);
         end
      end
   end

   task automatic issue(logic [3:0] op, logic [3:0] id);
      while (!no_idle && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {id, op};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits until every result is back, then lets the block settle before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (got_beats != sent_beats) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_pool(logic [5:0] pool, logic [5:0] cap);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= 1'b0;
      csr_wr_data <= pool;
      @(posedge clock);
      csr_index <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly pushes and pops so that the stack and the pool fill and empty again.
   function automatic logic [3:0] pick_op();
      int w;
      w = $urandom_range(99);
      if (w < 28) return rbsa_pkg::OP_PUSH_NEW;
      if (w < 48) return rbsa_pkg::OP_POP;
      if (w < 53) return rbsa_pkg::OP_PUSH_ID;
      if (w < 58) return rbsa_pkg::OP_DUP;
      if (w < 62) return rbsa_pkg::OP_DROP;
      if (w < 66) return rbsa_pkg::OP_SWAP;
      if (w < 70) return rbsa_pkg::OP_HOLD_POP;
      if (w < 74) return rbsa_pkg::OP_UHOLD_POP;
      if (w < 79) return rbsa_pkg::OP_UHOLD;
      if (w < 84) return rbsa_pkg::OP_URELEASE;
      if (w < 89) return rbsa_pkg::OP_RELEASE_HOLD;
      if (w < 93) return rbsa_pkg::OP_URELEASE_ALL;
      if (w < 97) return rbsa_pkg::OP_RESET;
      return 4'($urandom_range(13, 15));
   endfunction

   initial begin
      logic [5:0] pools [6];
      logic [5:0] caps [6];
      pools = '{6'd16, 6'd1, 6'd4, 6'd16, 6'd31, 6'd3};
      caps = '{6'd32, 6'd1, 6'd6, 6'd2, 6'd63, 6'd32};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_pool(6'd16, 6'd32);

      // Directed: allocation, stack shuffles, holds, releases and refusals.
      issue(rbsa_pkg::OP_POP, 4'd0);
      issue(rbsa_pkg::OP_SWAP, 4'd0);
      issue(rbsa_pkg::OP_PUSH_NEW, 4'd0);
      issue(rbsa_pkg::OP_PUSH_NEW, 4'd0);
      issue(rbsa_pkg::OP_DUP, 4'd0);
      issue(rbsa_pkg::OP_SWAP, 4'd0);
      issue(rbsa_pkg::OP_POP, 4'd0);
      issue(rbsa_pkg::OP_POP, 4'd0);
      issue(rbsa_pkg::OP_PUSH_NEW, 4'd0);
      issue(rbsa_pkg::OP_PUSH_ID, 4'd15);
      issue(rbsa_pkg::OP_DROP, 4'd0);
      issue(rbsa_pkg::OP_HOLD_POP, 4'd0);
      issue(rbsa_pkg::OP_UHOLD_POP, 4'd0);
      issue(rbsa_pkg::OP_UHOLD, 4'd3);
      issue(rbsa_pkg::OP_UHOLD, 4'd3);
      issue(rbsa_pkg::OP_URELEASE, 4'd5);
      issue(rbsa_pkg::OP_RELEASE_HOLD, 4'd7);
      issue(rbsa_pkg::OP_RELEASE_HOLD, 4'd0);
      issue(rbsa_pkg::OP_URELEASE_ALL, 4'd0);
      issue(rbsa_pkg::OP_URELEASE_ALL, 4'd0);
      issue(4'd13, 4'd0);
      issue(4'd15, 4'd15);
      issue(rbsa_pkg::OP_RESET, 4'd0);
      set_pool(6'd4, 6'd3);
      issue(rbsa_pkg::OP_PUSH_ID, 4'd9);
      issue(rbsa_pkg::OP_UHOLD, 4'd12);

      for (int ph = 0; ph < 6; ph++) begin
         set_pool(pools[ph], caps[ph]);
         no_idle = (ph == 2);
         if (ph == 1) stall_request = 1'b1;
         for (int n = 0; n < 155; n++)
            issue(pick_op(), 4'($urandom_range(15)));
      end
      no_idle = 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && checker_i.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end
endmodule
